### rtl/hkrb_pkg.sv
// Shared types and constants for the HID key report builder.
package hkrb_pkg;

  // Number of key slots carried in one report transfer
  localparam int unsigned OUT_SLOTS = 6;

  localparam logic [7:0] NO_KEY_CODE = 8'h00;
  // Modifier usage codes (left ctrl .. right gui)
  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam logic [7:0] MOD_LAST  = 8'hE7;

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [7:0] key_code;
    logic [1:0] opcode;
  } key_event_t;

  typedef struct packed {
    logic [7:0] slot_zero;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
  } key_report_t;

endpackage

### rtl/hid_key_report_builder.sv
// Key report builder: turns press/release events into six-slot HID key reports.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   event   | in        | in_valid_i/in_stall_o   | in_data_i  (key_event_t)
//   report  | out       | out_valid_o/out_stall_i | out_data_o (key_report_t)
//
// One event is taken per cycle while in_stall_o is low; its report enters the
// output register, or the skid register while a report waits. Slot match, clear
// and the compaction pass are parallel compare/select logic before the slots.
// A two-entry output buffer (report register plus skid register) lets an event
// be taken while a report waits; in_stall_o rises only when both are full.
// Reset clears all slots, the fill index and both output entries' valid flags.
// Press/release of key code zero and the unused opcode give no report.
module hid_key_report_builder #(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hkrb_pkg::key_event_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output hkrb_pkg::key_report_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(REPORT_SLOTS + 1);

  // Visible slots 0..REPORT_SLOTS-1, hidden slot at REPORT_SLOTS
  logic [7:0]       slots_q [REPORT_SLOTS+1];
  logic [7:0]       slots_d [REPORT_SLOTS+1];
  logic [IDX_W-1:0] fill_q, fill_d;

  logic [7:0] cleared [REPORT_SLOTS+1];
  logic [7:0] packed_slots [REPORT_SLOTS+1];
  logic [7:0] rep [hkrb_pkg::OUT_SLOTS];

  hkrb_pkg::key_report_t out_q, skid_q, new_rep;
  logic                  out_valid_q, skid_valid_q;

  logic [7:0] code;
  logic       is_mod, has_result, in_fire, out_fire, produce;
  logic       found, seen, hit;

  assign code   = in_data_i.key_code;
  assign is_mod = (code >= hkrb_pkg::MOD_FIRST) && (code <= hkrb_pkg::MOD_LAST);

  // Which events give a report
  always_comb begin
    case (in_data_i.opcode) inside
      hkrb_pkg::OP_RELEASE_ALL: has_result = 1'b1;
      hkrb_pkg::OP_PRESS,
      hkrb_pkg::OP_RELEASE:     has_result = (code != hkrb_pkg::NO_KEY_CODE);
      default:                  has_result = 1'b0;
    endcase
  end

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign produce     = in_fire & has_result;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q & ~out_stall_i;

  // Release path: clear first matching visible slot, then one compaction pass.
  // A pass shifts everything right of the first empty slot left by one.
  always_comb begin
    found = 1'b0;
    hit   = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      hit        = (slots_q[i] == code) && !found;
      cleared[i] = hit ? hkrb_pkg::NO_KEY_CODE : slots_q[i];
      found      = found | hit;
    end
    cleared[REPORT_SLOTS] = slots_q[REPORT_SLOTS];

    seen = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      seen = seen | (cleared[i] == hkrb_pkg::NO_KEY_CODE);
      if (!seen) begin
        packed_slots[i] = cleared[i];
      end else if (i + 1 < REPORT_SLOTS) begin
        packed_slots[i] = cleared[i+1];
      end else begin
        packed_slots[i] = hkrb_pkg::NO_KEY_CODE;
      end
    end
    packed_slots[REPORT_SLOTS] = cleared[REPORT_SLOTS];
  end

  // Next slot state and fill index
  always_comb begin
    slots_d = slots_q;
    fill_d  = fill_q;
    case (in_data_i.opcode)
      hkrb_pkg::OP_PRESS: begin
        for (int i = 0; i <= REPORT_SLOTS; i++) begin
          if (fill_q == IDX_W'(i)) begin
            slots_d[i] = code;
          end
        end
        if (is_mod && (fill_q < IDX_W'(REPORT_SLOTS))) begin
          fill_d = fill_q + IDX_W'(1);
        end
      end
      hkrb_pkg::OP_RELEASE: begin
        slots_d = packed_slots;
        if (is_mod && (fill_q != '0)) begin
          fill_d = fill_q - IDX_W'(1);
        end
      end
      default: begin
        for (int i = 0; i <= REPORT_SLOTS; i++) begin
          slots_d[i] = hkrb_pkg::NO_KEY_CODE;
        end
        fill_d = '0;
      end
    endcase
  end

  // Report from the new visible slots; fields past REPORT_SLOTS read zero
  always_comb begin
    for (int j = 0; j < hkrb_pkg::OUT_SLOTS; j++) begin
      rep[j] = (j < REPORT_SLOTS) ? slots_d[j] : hkrb_pkg::NO_KEY_CODE;
    end
    new_rep.slot_zero  = rep[0];
    new_rep.slot_one   = rep[1];
    new_rep.slot_two   = rep[2];
    new_rep.slot_three = rep[3];
    new_rep.slot_four  = rep[4];
    new_rep.slot_five  = rep[5];
  end

  // Slot state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= REPORT_SLOTS; i++) begin
        slots_q[i] <= hkrb_pkg::NO_KEY_CODE;
      end
      fill_q <= '0;
    end else if (produce) begin
      slots_q <= slots_d;
      fill_q  <= fill_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= produce;
        end
      end else if (produce) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Report payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (produce) begin
        out_q <= new_rep;
      end
    end else if (produce) begin
      skid_q <= new_rep;
    end
  end

endmodule
